### hdl/sqe_pkg.sv
`timescale 1ns / 1ps

package sqe_pkg;

    localparam int DEPTH  = 64;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = PTR_W + 1;
    localparam int DATA_W = 32;
    localparam int OP_W   = 3;
    localparam int ST_W   = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 3'd0,
        OP_LIST = 3'd1,
        OP_PEEK = 3'd2,
        OP_POP  = 3'd3,
        OP_NOP  = 3'd4
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK         = 2'd0,
        ST_EMPTY      = 2'd1,
        ST_FULL       = 2'd2,
        ST_EMPTY_LIST = 2'd3
    } st_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PEEK,
        S_LIST
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic push;
        logic pop;
        logic rd_first;
        logic rd_next;
        logic load_rsp;
        logic load_ram;
        st_t  status;
        logic last;
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic full;
        logic out_free;
        logic last_entry;
    } dp_stat_t;

endpackage

### hdl/sqe_cfg_if.sv
`timescale 1ns / 1ps

interface sqe_cfg_if;
    logic valid;
    logic ready;
    logic queue_mode;

    modport source (output valid, output queue_mode, input ready);
    modport sink (input valid, input queue_mode, output ready);
endinterface

### hdl/sqe_cmd_if.sv
`timescale 1ns / 1ps

interface sqe_cmd_if;
    logic                               valid;
    logic                               ready;
    logic [sqe_pkg::OP_W-1:0]           op;
    logic signed [sqe_pkg::DATA_W-1:0]  push_value;

    modport source (output valid, output op, output push_value, input ready);
    modport sink (input valid, input op, input push_value, output ready);
endinterface

### hdl/sqe_rsp_if.sv
`timescale 1ns / 1ps

interface sqe_rsp_if;
    logic                               valid;
    logic                               ready;
    logic signed [sqe_pkg::DATA_W-1:0]  data_value;
    logic [sqe_pkg::ST_W-1:0]           status;
    logic                               last_of_run;

    modport source (output valid, output data_value, output status, output last_of_run,
                    input ready);
    modport sink (input valid, input data_value, input status, input last_of_run,
                  output ready);
endinterface

### hdl/sqe_ram.sv
`timescale 1ns / 1ps

module sqe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/sqe_ctrl.sv
`timescale 1ns / 1ps

module sqe_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cmd_valid,
    input  logic [sqe_pkg::OP_W-1:0] cmd_op,
    output logic                     cmd_ready,
    input  sqe_pkg::dp_stat_t        stat,
    output sqe_pkg::ctl_t            ctl
);

    sqe_pkg::state_t state_reg;
    sqe_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sqe_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd_ready    = 1'b0;
        ctl          = '0;
        ctl.status   = sqe_pkg::ST_OK;
        unique case (state_reg)
            sqe_pkg::S_IDLE:
            begin
                cmd_ready = stat.out_free;
                if (cmd_valid && stat.out_free)
                begin
                    unique case (sqe_pkg::op_t'(cmd_op))
                        sqe_pkg::OP_PUSH:
                        begin
                            ctl.load_rsp = 1'b1;
                            ctl.last     = 1'b1;
                            if (stat.full)
                            begin
                                ctl.status = sqe_pkg::ST_FULL;
                            end
                            else
                            begin
                                ctl.push = 1'b1;
                            end
                        end
                        sqe_pkg::OP_LIST:
                        begin
                            if (stat.empty)
                            begin
                                ctl.load_rsp = 1'b1;
                                ctl.last     = 1'b1;
                                ctl.status   = sqe_pkg::ST_EMPTY_LIST;
                            end
                            else
                            begin
                                ctl.rd_first = 1'b1;
                                state_next   = sqe_pkg::S_LIST;
                            end
                        end
                        sqe_pkg::OP_PEEK:
                        begin
                            if (stat.empty)
                            begin
                                ctl.load_rsp = 1'b1;
                                ctl.last     = 1'b1;
                                ctl.status   = sqe_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                ctl.rd_first = 1'b1;
                                state_next   = sqe_pkg::S_PEEK;
                            end
                        end
                        sqe_pkg::OP_POP:
                        begin
                            ctl.load_rsp = 1'b1;
                            ctl.last     = 1'b1;
                            if (stat.empty)
                            begin
                                ctl.status = sqe_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                ctl.pop = 1'b1;
                            end
                        end
                        default:
                        begin
                            ctl.load_rsp = 1'b1;
                            ctl.last     = 1'b1;
                        end
                    endcase
                end
            end
            sqe_pkg::S_PEEK:
            begin
                if (stat.out_free)
                begin
                    ctl.load_rsp = 1'b1;
                    ctl.load_ram = 1'b1;
                    ctl.last     = 1'b1;
                    state_next   = sqe_pkg::S_IDLE;
                end
            end
            sqe_pkg::S_LIST:
            begin
                if (stat.out_free)
                begin
                    ctl.load_rsp = 1'b1;
                    ctl.load_ram = 1'b1;
                    ctl.last     = stat.last_entry;
                    if (stat.last_entry)
                    begin
                        state_next = sqe_pkg::S_IDLE;
                    end
                    else
                    begin
                        ctl.rd_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = sqe_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### hdl/sqe_dp.sv
`timescale 1ns / 1ps

module sqe_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic                              cfg_queue_mode,
    input  logic signed [sqe_pkg::DATA_W-1:0] push_value,
    input  sqe_pkg::ctl_t                     ctl,
    output sqe_pkg::dp_stat_t                 stat,
    input  logic                              rsp_ready,
    output logic                              rsp_valid,
    output logic signed [sqe_pkg::DATA_W-1:0] rsp_data,
    output logic [sqe_pkg::ST_W-1:0]          rsp_status,
    output logic                              rsp_last
);

    localparam int PTR_W = sqe_pkg::PTR_W;
    localparam int CNT_W = sqe_pkg::CNT_W;

    // modular add of two ring indexes
    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] a,
                                                  input logic [PTR_W-1:0] b);
        logic [PTR_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= (PTR_W+1)'(sqe_pkg::DEPTH))
        begin
            sum = sum - (PTR_W+1)'(sqe_pkg::DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    logic                              queue_mode_reg;
    logic [PTR_W-1:0]                  top_reg;
    logic [PTR_W-1:0]                  top_next;
    logic [CNT_W-1:0]                  count_reg;
    logic [CNT_W-1:0]                  count_next;
    logic [PTR_W-1:0]                  idx_reg;
    logic [PTR_W-1:0]                  idx_next;
    logic                              rsp_valid_reg;
    logic signed [sqe_pkg::DATA_W-1:0] rsp_data_reg;
    logic [sqe_pkg::ST_W-1:0]          rsp_status_reg;
    logic                              rsp_last_reg;

    logic [PTR_W-1:0]                  top_dec;
    logic [PTR_W-1:0]                  idx_inc;
    logic                              wr_en;
    logic [PTR_W-1:0]                  wr_addr;
    logic                              rd_en;
    logic [PTR_W-1:0]                  rd_addr;
    logic [sqe_pkg::DATA_W-1:0]        rd_data;

    assign top_dec = wrap_add(top_reg, PTR_W'(sqe_pkg::DEPTH - 1));
    assign idx_inc = idx_reg + PTR_W'(1);

    always_comb
    begin
        top_next   = top_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        wr_en      = 1'b0;
        wr_addr    = top_dec;
        rd_en      = 1'b0;
        rd_addr    = top_reg;
        if (ctl.push)
        begin
            wr_en      = 1'b1;
            count_next = count_reg + CNT_W'(1);
            if (queue_mode_reg)
            begin
                wr_addr = wrap_add(top_reg, count_reg[PTR_W-1:0]);
            end
            else
            begin
                top_next = top_dec;
            end
        end
        if (ctl.pop)
        begin
            top_next   = wrap_add(top_reg, PTR_W'(1));
            count_next = count_reg - CNT_W'(1);
        end
        if (ctl.rd_first)
        begin
            rd_en    = 1'b1;
            idx_next = '0;
        end
        if (ctl.rd_next)
        begin
            rd_en    = 1'b1;
            rd_addr  = wrap_add(top_reg, idx_inc);
            idx_next = idx_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queue_mode_reg <= 1'b0;
            top_reg        <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                queue_mode_reg <= cfg_queue_mode;
            end
            top_reg   <= top_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            if (ctl.load_rsp)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_rsp)
        begin
            rsp_data_reg   <= ctl.load_ram ? rd_data : '0;
            rsp_status_reg <= ctl.status;
            rsp_last_reg   <= ctl.last;
        end
    end

    sqe_ram #(
        .WIDTH (sqe_pkg::DATA_W),
        .DEPTH (sqe_pkg::DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (push_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign stat.empty      = (count_reg == '0);
    assign stat.full       = (count_reg == CNT_W'(sqe_pkg::DEPTH));
    assign stat.out_free   = !rsp_valid_reg || rsp_ready;
    assign stat.last_entry = (({1'b0, idx_reg} + CNT_W'(1)) == count_reg);

    assign rsp_valid  = rsp_valid_reg;
    assign rsp_data   = rsp_data_reg;
    assign rsp_status = rsp_status_reg;
    assign rsp_last   = rsp_last_reg;

endmodule

### hdl/stack_queue_engine.sv
`timescale 1ns / 1ps

// Bounded stack/queue of signed 32-bit values, DEPTH entries in a ring buffer.
// cfg: one-beat write of queue_mode (0 stack, 1 queue); always ready. Write it
//   only while the engine is idle.
// cmd: one beat per operation (op, push_value). rsp: one or more beats per
//   command, last_of_run set on the final beat.
// Push, pop, nop and all error cases: the response beat is valid the cycle
//   after the command beat; a new command is taken every cycle while rsp keeps
//   up.
// Peek: the command starts a store read, and the read data is loaded into the
//   output register once it is free. List: the command starts the first store
//   read; the entries then follow, one beat per cycle while rsp keeps up;
//   cmd.ready stays low until the last beat is loaded. The single store read port sets this rate.
// A one-entry output register separates rsp from cmd: cmd is accepted while a
//   response still waits, as long as it is taken in the same cycle.
// When rsp.ready is low, the pending beat holds and cmd.ready drops.
// Reset clears the pointers, the count, queue_mode and the pending beat; the
//   store contents are left as they are and need no clearing.
module stack_queue_engine (
    input  logic      clk,
    input  logic      rst_n,
    sqe_cfg_if.sink   cfg,
    sqe_cmd_if.sink   cmd,
    sqe_rsp_if.source rsp
);

    sqe_pkg::ctl_t     ctl;
    sqe_pkg::dp_stat_t stat;

    assign cfg.ready = 1'b1;

    sqe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_op    (cmd.op),
        .cmd_ready (cmd.ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    sqe_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg.valid),
        .cfg_queue_mode (cfg.queue_mode),
        .push_value     (cmd.push_value),
        .ctl            (ctl),
        .stat           (stat),
        .rsp_ready      (rsp.ready),
        .rsp_valid      (rsp.valid),
        .rsp_data       (rsp.data_value),
        .rsp_status     (rsp.status),
        .rsp_last       (rsp.last_of_run)
    );

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load_rsp |-> stat.out_free)
        else $error("response loaded over a pending beat");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.push |=> !stat.empty)
        else $error("store empty after push");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.push |-> !stat.full)
        else $error("push into full store");

    a_list_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.rd_next |-> !stat.last_entry && !stat.empty)
        else $error("list read past last entry");

endmodule
